// ===== design/caalu_pkg.sv =====
// Package with the item types, opcodes and constants of the 32-bit expression ALU.
package caalu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CountBits = 6;
  localparam int unsigned DivStages = DataWidth;

  typedef enum logic [4:0] {
    OP_OR   = 5'd0,
    OP_AND  = 5'd1,
    OP_SLA  = 5'd2,
    OP_SLL  = 5'd3,
    OP_SRA  = 5'd4,
    OP_SRL  = 5'd5,
    OP_XOR  = 5'd6,
    OP_EQ   = 5'd7,
    OP_LE   = 5'd8,
    OP_LT   = 5'd9,
    OP_GE   = 5'd10,
    OP_GT   = 5'd11,
    OP_NE   = 5'd12,
    OP_ADD  = 5'd13,
    OP_SUB  = 5'd14,
    OP_MUL  = 5'd15,
    OP_DIV  = 5'd16,
    OP_NOT  = 5'd17,
    OP_NEG  = 5'd18,
    OP_PLUS = 5'd19
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_PROP = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_MUL   = 2'd1,
    KIND_DIV   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [4:0]                  req_type;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
    logic                        a_has_error;
    logic                        b_has_error;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        result_is_logic;
    logic [1:0]                  error_code;
  } rsp_t;

  // Item state carried down the pipeline beside the divider.
  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [DataWidth-1:0] res;
    logic                 is_logic;
    err_e                 err;
    logic                 q_neg;
  } info_t;

endpackage

// ===== design/caalu_decode.sv =====
// First-stage decode: error checks, logic, shifts, compares, add/sub, unary ops, multiply marking and divider setup.
module caalu_decode (
  input  logic                         valid_i,
  input  caalu_pkg::req_t              req_i,
  output caalu_pkg::info_t             info_o,
  output logic [caalu_pkg::DataWidth-1:0] div_num_o,
  output logic [caalu_pkg::DataWidth-1:0] div_den_o
);
  import caalu_pkg::*;

  logic [DataWidth-1:0]   ua;
  logic [DataWidth-1:0]   ub;
  logic [CountBits-1:0]   n;
  logic [DataWidth:0]     sum;
  logic [DataWidth:0]     dif;
  logic [DataWidth-2:0]   sla_low;
  logic [DataWidth-1:0]   sra_res;
  logic                   prop;
  logic                   a_min;

  always_comb begin
    ua      = req_i.operand_a;
    ub      = req_i.operand_b;
    n       = ub[CountBits-1:0];
    sum     = {ua[DataWidth-1], ua} + {ub[DataWidth-1], ub};
    dif     = {ua[DataWidth-1], ua} - {ub[DataWidth-1], ub};
    sla_low = ua[DataWidth-2:0] << n;
    sra_res = (n[CountBits-1]) ? {DataWidth{ua[DataWidth-1]}}
                               : DataWidth'($signed(ua) >>> n[CountBits-2:0]);
    a_min   = (ua == {1'b1, {(DataWidth-1){1'b0}}});
    div_num_o = ua[DataWidth-1] ? (~ua + 1'b1) : ua;
    div_den_o = ub[DataWidth-1] ? (~ub + 1'b1) : ub;

    prop = 1'b0;
    if (req_i.req_type <= 5'(OP_DIV)) begin
      prop = req_i.a_has_error | req_i.b_has_error;
    end else if (req_i.req_type <= 5'(OP_PLUS)) begin
      prop = req_i.a_has_error;
    end

    info_o.valid    = valid_i;
    info_o.kind     = KIND_PLAIN;
    info_o.res      = '0;
    info_o.err      = ERR_NONE;
    info_o.q_neg    = ua[DataWidth-1] ^ ub[DataWidth-1];
    info_o.is_logic = (req_i.req_type >= 5'(OP_EQ)) && (req_i.req_type <= 5'(OP_NE));

    if (prop) begin
      info_o.err = ERR_PROP;
    end else begin
      unique case (req_i.req_type)
        OP_OR:  info_o.res = ua | ub;
        OP_AND: info_o.res = ua & ub;
        OP_SLA: begin
          if (n >= CountBits'(DataWidth - 1)) begin
            info_o.res = {ua[DataWidth-1], {(DataWidth-1){1'b0}}};
          end else begin
            info_o.res = {ua[DataWidth-1], sla_low};
          end
        end
        OP_SLL: info_o.res = n[CountBits-1] ? '0 : (ua << n[CountBits-2:0]);
        OP_SRA: info_o.res = sra_res;
        OP_SRL: info_o.res = n[CountBits-1] ? '0 : (ua >> n[CountBits-2:0]);
        OP_XOR: info_o.res = ua ^ ub;
        OP_EQ:  info_o.res = DataWidth'(ua == ub);
        OP_LE:  info_o.res = DataWidth'($signed(ua) <= $signed(ub));
        OP_LT:  info_o.res = DataWidth'($signed(ua) <  $signed(ub));
        OP_GE:  info_o.res = DataWidth'($signed(ua) >= $signed(ub));
        OP_GT:  info_o.res = DataWidth'($signed(ua) >  $signed(ub));
        OP_NE:  info_o.res = DataWidth'(ua != ub);
        OP_ADD: begin
          if (sum[DataWidth] != sum[DataWidth-1]) info_o.err = ERR_OVF;
          else info_o.res = sum[DataWidth-1:0];
        end
        OP_SUB: begin
          if (dif[DataWidth] != dif[DataWidth-1]) info_o.err = ERR_OVF;
          else info_o.res = dif[DataWidth-1:0];
        end
        OP_MUL: info_o.kind = KIND_MUL;
        OP_DIV: begin
          // Divide by zero gives a plain zero; the most negative value over
          // minus one does not fit and is flagged.
          if (ub == '0) begin
            info_o.res = '0;
          end else if (a_min && (ub == '1)) begin
            info_o.err = ERR_OVF;
          end else begin
            info_o.kind = KIND_DIV;
          end
        end
        OP_NOT: info_o.res = ~ua;
        OP_NEG: begin
          if (a_min) info_o.err = ERR_OVF;
          else info_o.res = ~ua + 1'b1;
        end
        OP_PLUS: info_o.res = ua;
        default: info_o.res = '0;
      endcase
    end
  end

endmodule

// ===== design/caalu_mul.sv =====
// Registered 32 by 32 signed multiplier.
module caalu_mul (
  input  logic                              clk_i,
  input  logic [caalu_pkg::DataWidth-1:0]   a_i,
  input  logic [caalu_pkg::DataWidth-1:0]   b_i,
  output logic [2*caalu_pkg::DataWidth-1:0] prod_o
);
  import caalu_pkg::*;

  logic signed [2*DataWidth-1:0] prod_d;
  logic [2*DataWidth-1:0]        prod_q;

  always_comb begin
    prod_d = $signed(a_i) * $signed(b_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/caalu_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module caalu_div (
  input  logic                            clk_i,
  input  logic [caalu_pkg::DataWidth-1:0] num_i,
  input  logic [caalu_pkg::DataWidth-1:0] den_i,
  output logic [caalu_pkg::DataWidth-1:0] quo_o
);
  import caalu_pkg::*;

  logic [DataWidth-1:0] rem_q [DivStages];
  logic [DataWidth-1:0] num_q [DivStages];
  logic [DataWidth-1:0] den_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [DataWidth-1:0] rem_in;
    logic [DataWidth-1:0] num_in;
    logic [DataWidth-1:0] den_in;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;
    logic [DataWidth-1:0] rem_d;
    logic [DataWidth-1:0] num_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[DataWidth-1]};
      diff  = trial - {1'b0, den_in};
      if (!diff[DataWidth]) begin
        rem_d = diff[DataWidth-1:0];
        num_d = {num_in[DataWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[DataWidth-1:0];
        num_d = {num_in[DataWidth-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      num_q[k] <= num_d;
      den_q[k] <= den_in;
    end
  end

  assign quo_o = num_q[DivStages-1];

endmodule

// ===== design/conditional_assembly_alu32.sv =====
// Top level of the pipelined 32-bit expression ALU.
//
//   channel   signals                     direction  handshake
//   request   start_i, busy_o, req_i      in         taken when start_i && !busy_o
//   result    valid_o, rsp_o              out        one-cycle strobe, no back-pressure
//
// Every item passes the input register, the second stage, the delay line level with
// the divider and the output register, whatever the opcode, so results leave in
// request order.
// The divider produces one quotient bit per stage.
// A new item may be started in every cycle; busy_o is always low.
// Reset clears the valid bits and item state; other data registers carry no reset.
module conditional_assembly_alu32 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  caalu_pkg::req_t  req_i,
  output logic             valid_o,
  output caalu_pkg::rsp_t  rsp_o
);
  import caalu_pkg::*;

  // Input register stage.
  logic  in_valid_q;
  req_t  req_q;

  // Decode results.
  info_t                info_dec;
  logic [DataWidth-1:0] div_num;
  logic [DataWidth-1:0] div_den;

  // Second stage with the product alongside.
  info_t                info_b_q;
  info_t                info_b;
  logic [2*DataWidth-1:0] prod;

  // Delay line that keeps item state level with the divider.
  info_t                dly_q [DivStages-1];
  logic [DataWidth-1:0] quo;

  // Output register.
  logic  valid_q;
  rsp_t  rsp_d;
  rsp_t  rsp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  caalu_decode u_decode (
    .valid_i   (in_valid_q),
    .req_i     (req_q),
    .info_o    (info_dec),
    .div_num_o (div_num),
    .div_den_o (div_den)
  );

  caalu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (req_q.operand_a),
    .b_i    (req_q.operand_b),
    .prod_o (prod)
  );

  caalu_div u_div (
    .clk_i (clk_i),
    .num_i (div_num),
    .den_i (div_den),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_b_q <= '0;
    end else begin
      info_b_q <= info_dec;
    end
  end

  // The product is out of range when its upper half is not a sign extension
  // of bit 31.
  always_comb begin
    info_b = info_b_q;
    if (info_b_q.kind == KIND_MUL) begin
      info_b.kind = KIND_PLAIN;
      if ((prod[2*DataWidth-1:DataWidth-1] != '0) &&
          (prod[2*DataWidth-1:DataWidth-1] != '1)) begin
        info_b.err = ERR_OVF;
        info_b.res = '0;
      end else begin
        info_b.res = prod[DataWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages - 1; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      dly_q[0] <= info_b;
      for (int i = 1; i < DivStages - 1; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // The quotient magnitude is signed again here for division items.
  always_comb begin
    rsp_d.result_is_logic = dly_q[DivStages-2].is_logic;
    rsp_d.error_code      = dly_q[DivStages-2].err;
    if (dly_q[DivStages-2].kind == KIND_DIV) begin
      rsp_d.result_value = dly_q[DivStages-2].q_neg ? (~quo + 1'b1) : quo;
    end else begin
      rsp_d.result_value = dly_q[DivStages-2].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dly_q[DivStages-2].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
